@@ rtl/lbd_pkg.sv @@
// shared types and constants for the link break supervisor
package lbd_pkg;

    // request codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_EVAL   = 2'd2;
    localparam logic [1:0] FUNC_INIT   = 2'd3;

    // link sequence codes
    localparam logic [2:0] LINK_NORMAL  = 3'd0;
    localparam logic [2:0] LINK_BREAK   = 3'd1;
    localparam logic [2:0] LINK_VERIFY  = 3'd2;
    localparam logic [2:0] LINK_SUCCESS = 3'd3;
    localparam logic [2:0] LINK_FAILED  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ACCUM_START = 3'd0;
    localparam logic [2:0] CFG_BREAK_THR   = 3'd1;
    localparam logic [2:0] CFG_VERIFY_THR  = 3'd2;
    localparam logic [2:0] CFG_WINDOW_MS   = 3'd3;
    localparam logic [2:0] CFG_MASK_MS     = 3'd4;
    localparam logic [2:0] CFG_ATTEMPTS    = 3'd5;

    // configuration reset values
    localparam logic [7:0]  RST_ACCUM_START = 8'd5;
    localparam logic [7:0]  RST_BREAK_THR   = 8'd25;
    localparam logic [7:0]  RST_VERIFY_THR  = 8'd5;
    localparam logic [15:0] RST_WINDOW_MS   = 16'd4000;
    localparam logic [15:0] RST_MASK_MS     = 16'd1500;
    localparam logic [3:0]  RST_ATTEMPTS    = 4'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] chip_index;
        logic [7:0] error_increment;
    } in_t;

    typedef struct packed {
        logic [2:0] link_state;
        logic [4:0] break_position;
        logic       noncritical_fault;
        logic       critical_latched;
        logic       recovered_once;
        logic       startup_masked;
        logic       reroute_pulse;
        logic       comm_break_pulse;
        logic       status_send_pulse;
    } out_t;

endpackage

@@ rtl/link_break_detect_recovery.sv @@
// link break supervisor: error sums, timers and break recovery sequence
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+-------------------------------
//  s_       | s_valid s_ready s_data           | one request (tick/report/eval/init)
//  m_       | m_valid m_ready m_data           | one status result per request
//  cfg_     | cfg_valid cfg_ready cfg_index/data | one register write
//
// tick and init go from dispatch to the result; a report adds a sum write step.
// an evaluate step that scans the sums runs from its start chip to the last;
// the scan reads one chip sum a cycle from the sum memory through one comparator.
// reset is synchronous, active low; the sums are cleared at once through
// per-chip valid bits, so no clearing pass is needed.
// s_ready is low from accept until the result is taken on the m_ side.
module link_break_detect_recovery #(
    parameter int CHAIN_LENGTH = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lbd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output lbd_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import lbd_pkg::*;

    localparam int AW  = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam int BPW = $clog2(CHAIN_LENGTH + 1);
    localparam int IW  = (AW > 4) ? AW : 4;
    localparam int BPX = (BPW > 5) ? BPW : 5;
    localparam logic [AW-1:0] LAST = AW'(CHAIN_LENGTH - 1);

    // sequencer codes
    localparam logic [2:0] SEQ_IDLE   = 3'd0;
    localparam logic [2:0] SEQ_DISP   = 3'd1;
    localparam logic [2:0] SEQ_ADD    = 3'd2;
    localparam logic [2:0] SEQ_SCAN   = 3'd3;
    localparam logic [2:0] SEQ_FINISH = 3'd4;
    localparam logic [2:0] SEQ_OUT    = 3'd5;

    // scan modes
    localparam logic [1:0] MODE_SPIKE  = 2'd0;
    localparam logic [1:0] MODE_BREAK  = 2'd1;
    localparam logic [1:0] MODE_VERIFY = 2'd2;

    // configuration registers
    logic [7:0]  accum_thr_reg, break_thr_reg, verify_thr_reg;
    logic [15:0] window_ms_reg, mask_ms_reg;
    logic [3:0]  attempt_lim_reg;

    // block state
    logic [2:0]        seq_reg, seq_next;
    logic [2:0]        link_reg, link_next;
    logic [BPW-1:0]    bp_reg, bp_next;
    logic [3:0]        attempt_reg, attempt_next;
    logic              recovered_reg, recovered_next;
    logic              latched_reg, latched_next;
    logic              fault_reg, fault_next;
    logic              win_act_reg, win_act_next;
    logic [15:0]       win_rem_reg, win_rem_next;
    logic [15:0]       mask_rem_reg, mask_rem_next;
    logic [CHAIN_LENGTH-1:0] sum_vld_reg, sum_vld_next;

    // pulses of the current request
    logic reroute_reg, reroute_next;
    logic comm_reg, comm_next;
    logic status_reg, status_next;

    // captured request
    in_t  req_reg;

    // scan engine
    logic [1:0]    mode_reg, mode_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic          all_reg, all_next;
    logic [AW-1:0] first_reg, first_next;

    // sum memory and its registered read port
    logic [15:0]   sum_mem [CHAIN_LENGTH];
    logic [15:0]   rd_data_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;

    // derived values
    logic [IW-1:0]  chip_ext;
    logic [AW-1:0]  chip_addr;
    logic           chip_ok;
    logic [15:0]    cur_sum;
    logic [16:0]    add_sum;
    logic [15:0]    sat_sum;
    logic [7:0]     scan_thr;
    logic           scan_gt;
    logic [AW-1:0]  scan_start;
    logic [BPX-1:0] bp_ext;

    assign chip_ext  = IW'(req_reg.chip_index);
    assign chip_addr = chip_ext[AW-1:0];
    assign chip_ok   = (32'(req_reg.chip_index) < CHAIN_LENGTH);
    assign cur_sum   = rd_vld_reg ? rd_data_reg : 16'd0;
    assign add_sum   = {1'b0, cur_sum} + {9'd0, req_reg.error_increment};
    assign sat_sum   = add_sum[16] ? 16'hFFFF : add_sum[15:0];
    assign scan_start = (bp_reg == '0) ? '0 : AW'(bp_reg - 1'b1);
    assign rd_addr   = (seq_reg == SEQ_SCAN) ? ptr_reg : chip_addr;
    assign mem_we    = (seq_reg == SEQ_ADD);

    // shared compare unit
    always_comb begin
        case (mode_reg)
            MODE_SPIKE:  scan_thr = accum_thr_reg;
            MODE_BREAK:  scan_thr = break_thr_reg;
            default:     scan_thr = verify_thr_reg;
        endcase
    end
    assign scan_gt = (cur_sum > {8'd0, scan_thr});

    // handshakes and result
    assign s_ready   = (seq_reg == SEQ_IDLE);
    assign m_valid   = (seq_reg == SEQ_OUT);
    assign cfg_ready = 1'b1;
    assign bp_ext    = BPX'(bp_reg);

    always_comb begin
        m_data.link_state        = link_reg;
        m_data.break_position    = bp_ext[4:0];
        m_data.noncritical_fault = fault_reg;
        m_data.critical_latched  = latched_reg;
        m_data.recovered_once    = recovered_reg;
        m_data.startup_masked    = (mask_rem_reg != 16'd0);
        m_data.reroute_pulse     = reroute_reg;
        m_data.comm_break_pulse  = comm_reg;
        m_data.status_send_pulse = status_reg;
    end

    // sequencer and state update
    always_comb begin
        seq_next       = seq_reg;
        link_next      = link_reg;
        bp_next        = bp_reg;
        attempt_next   = attempt_reg;
        recovered_next = recovered_reg;
        latched_next   = latched_reg;
        fault_next     = fault_reg;
        win_act_next   = win_act_reg;
        win_rem_next   = win_rem_reg;
        mask_rem_next  = mask_rem_reg;
        sum_vld_next   = sum_vld_reg;
        reroute_next   = reroute_reg;
        comm_next      = comm_reg;
        status_next    = status_reg;
        mode_next      = mode_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        all_next       = all_reg;
        first_next     = first_reg;

        case (seq_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    reroute_next = 1'b0;
                    comm_next    = 1'b0;
                    status_next  = 1'b0;
                    seq_next     = SEQ_DISP;
                end
            end

            SEQ_DISP: begin
                seq_next = SEQ_OUT;
                case (req_reg.func)
                    FUNC_TICK: begin
                        if (mask_rem_reg != 16'd0)
                            mask_rem_next = mask_rem_reg - 16'd1;
                        if (win_act_reg && win_rem_reg != 16'd0)
                            win_rem_next = win_rem_reg - 16'd1;
                    end
                    FUNC_REPORT: begin
                        if (chip_ok)
                            seq_next = SEQ_ADD;
                    end
                    FUNC_INIT: begin
                        mask_rem_next  = mask_ms_reg;
                        win_act_next   = 1'b0;
                        win_rem_next   = 16'd0;
                        link_next      = LINK_NORMAL;
                        bp_next        = '0;
                        attempt_next   = 4'd0;
                        recovered_next = 1'b0;
                        latched_next   = 1'b0;
                        sum_vld_next   = '0;
                        status_next    = 1'b1;
                    end
                    default: begin
                        // evaluate step
                        hit_next   = 1'b0;
                        all_next   = 1'b1;
                        first_next = '0;
                        pend_next  = 1'b0;
                        issue_next = 1'b1;
                        case (link_reg)
                            LINK_NORMAL: begin
                                if (recovered_reg) begin
                                    sum_vld_next = '0;
                                end else if (!win_act_reg) begin
                                    mode_next = MODE_SPIKE;
                                    ptr_next  = '0;
                                    seq_next  = SEQ_SCAN;
                                end else if (win_rem_reg == 16'd0) begin
                                    win_act_next = 1'b0;
                                    mode_next    = MODE_BREAK;
                                    ptr_next     = '0;
                                    seq_next     = SEQ_SCAN;
                                end
                            end
                            LINK_BREAK: begin
                                status_next  = 1'b1;
                                reroute_next = 1'b1;
                                comm_next    = (bp_reg > BPW'(1));
                                sum_vld_next = '0;
                                link_next    = LINK_VERIFY;
                            end
                            LINK_VERIFY: begin
                                status_next = 1'b1;
                                if (attempt_reg >= attempt_lim_reg) begin
                                    link_next = LINK_FAILED;
                                end else begin
                                    mode_next = MODE_VERIFY;
                                    ptr_next  = scan_start;
                                    seq_next  = SEQ_SCAN;
                                end
                            end
                            LINK_SUCCESS: begin
                                status_next = 1'b1;
                                fault_next  = 1'b0;
                                link_next   = LINK_NORMAL;
                            end
                            LINK_FAILED: begin
                                if (!latched_reg) begin
                                    status_next    = 1'b1;
                                    recovered_next = 1'b0;
                                    latched_next   = 1'b1;
                                end
                                sum_vld_next = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                endcase
            end

            // saturating add into the reported chip
            SEQ_ADD: begin
                sum_vld_next[chip_addr] = 1'b1;
                seq_next = SEQ_OUT;
            end

            // one read issued and one sum compared per cycle
            SEQ_SCAN: begin
                if (issue_reg) begin
                    idx_next  = ptr_reg;
                    pend_next = 1'b1;
                    if (ptr_reg == LAST)
                        issue_next = 1'b0;
                    else
                        ptr_next = ptr_reg + 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (mode_reg == MODE_BREAK) begin
                        if (!hit_reg) begin
                            if (scan_gt) begin
                                hit_next   = 1'b1;
                                first_next = idx_reg;
                            end
                        end else if (!scan_gt) begin
                            all_next = 1'b0;
                        end
                    end else if (scan_gt) begin
                        hit_next = 1'b1;
                    end
                    if (idx_reg == LAST)
                        seq_next = SEQ_FINISH;
                end
            end

            // act on the scan result
            SEQ_FINISH: begin
                seq_next = SEQ_OUT;
                case (mode_reg)
                    MODE_SPIKE: begin
                        if (hit_reg) begin
                            win_act_next = 1'b1;
                            win_rem_next = window_ms_reg;
                        end else begin
                            sum_vld_next = '0;
                        end
                    end
                    MODE_BREAK: begin
                        if (hit_reg && all_reg) begin
                            link_next  = LINK_BREAK;
                            bp_next    = BPW'(first_reg) + BPW'(1);
                            fault_next = 1'b1;
                        end
                        sum_vld_next = '0;
                    end
                    default: begin
                        sum_vld_next = '0;
                        if (!hit_reg) begin
                            link_next      = LINK_SUCCESS;
                            recovered_next = 1'b1;
                        end
                        attempt_next = attempt_reg + 4'd1;
                    end
                endcase
            end

            SEQ_OUT: begin
                if (m_ready)
                    seq_next = SEQ_IDLE;
            end

            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= SEQ_IDLE;
            link_reg      <= LINK_NORMAL;
            bp_reg        <= '0;
            attempt_reg   <= 4'd0;
            recovered_reg <= 1'b0;
            latched_reg   <= 1'b0;
            fault_reg     <= 1'b0;
            win_act_reg   <= 1'b0;
            win_rem_reg   <= 16'd0;
            mask_rem_reg  <= 16'd0;
            sum_vld_reg   <= '0;
            reroute_reg   <= 1'b0;
            comm_reg      <= 1'b0;
            status_reg    <= 1'b0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            seq_reg       <= seq_next;
            link_reg      <= link_next;
            bp_reg        <= bp_next;
            attempt_reg   <= attempt_next;
            recovered_reg <= recovered_next;
            latched_reg   <= latched_next;
            fault_reg     <= fault_next;
            win_act_reg   <= win_act_next;
            win_rem_reg   <= win_rem_next;
            mask_rem_reg  <= mask_rem_next;
            sum_vld_reg   <= sum_vld_next;
            reroute_reg   <= reroute_next;
            comm_reg      <= comm_next;
            status_reg    <= status_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
        end
    end

    // scan datapath and captured request
    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        ptr_reg   <= ptr_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        all_reg   <= all_next;
        first_reg <= first_next;
        if (s_valid && s_ready)
            req_reg <= s_data;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_thr_reg   <= RST_ACCUM_START;
            break_thr_reg   <= RST_BREAK_THR;
            verify_thr_reg  <= RST_VERIFY_THR;
            window_ms_reg   <= RST_WINDOW_MS;
            mask_ms_reg     <= RST_MASK_MS;
            attempt_lim_reg <= RST_ATTEMPTS;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ACCUM_START: accum_thr_reg   <= cfg_data[7:0];
                CFG_BREAK_THR:   break_thr_reg   <= cfg_data[7:0];
                CFG_VERIFY_THR:  verify_thr_reg  <= cfg_data[7:0];
                CFG_WINDOW_MS:   window_ms_reg   <= cfg_data;
                CFG_MASK_MS:     mask_ms_reg     <= cfg_data;
                CFG_ATTEMPTS:    attempt_lim_reg <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // sum memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we)
            sum_mem[chip_addr] <= sat_sum;
        rd_data_reg <= sum_mem[rd_addr];
        rd_vld_reg  <= sum_vld_reg[rd_addr];
    end

endmodule
